// ===== sv/swm_pkg.sv =====
// Shared constants and control types for the sliding-window maximum filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int WS_W        = 7;
  localparam int IDX_W       = $clog2(WINDOW_MAX);
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int POS_W       = $clog2(4 * WINDOW_MAX);
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RETIRE,
    S_PUSH
  } swm_state_t;

  typedef struct packed {
    logic capture;
    logic retire;
    logic push;
  } swm_cmd_t;

  typedef struct packed {
    logic front_expired;
    logic out_free;
  } swm_status_t;

endpackage

// ===== sv/swm_ctrl.sv =====
// Controller for the sliding-window maximum filter: sequences capture,
// front retirement and the push step. Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_ctrl import swm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  swm_status_t status,
  output swm_cmd_t    cmd
);

  swm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_RETIRE;
      end
      S_RETIRE: begin
        if (!status.front_expired) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_RETIRE: begin
        cmd.retire = status.front_expired;
      end
      S_PUSH: begin
        cmd.push = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/swm_dp.sv =====
// Datapath for the sliding-window maximum filter: deque cells with parallel
// compare, counters, window size register and result register. Uses swm_pkg.
`timescale 1ns / 1ps

module swm_dp import swm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [WS_W-1:0]               cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_first,
  input  logic                          in_last,
  input  swm_cmd_t                      cmd,
  output swm_status_t                   status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_max,
  output logic                          out_last
);

  // cell 0 is the deque front; valid bits always form a prefix
  logic signed [SAMPLE_BITS-1:0] cval_r [WINDOW_MAX];
  logic [POS_W-1:0]              cpos_r [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]         valid_r;

  logic [WS_W-1:0]               ws_r;
  logic [POS_W-1:0]              pos_r;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic                          last_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_max_r;
  logic                          out_last_r;

  logic [CNT_W-1:0]              win_k;
  logic [POS_W-1:0]              age;
  logic [WINDOW_MAX-1:0]         surv, load;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] front_val;

  always_comb begin
    if (ws_r == '0) begin
      win_k = CNT_W'(1);
    end else if (32'(ws_r) > 32'(WINDOW_MAX)) begin
      win_k = CNT_W'(WINDOW_MAX);
    end else begin
      win_k = CNT_W'(ws_r);
    end
  end

  assign age                  = pos_r - cpos_r[0];
  assign status.front_expired = valid_r[0] && (32'(age) >= 32'(win_k));
  assign status.out_free      = !out_valid_r || out_ready;

  // entries not greater than the new sample die; the survivors stay a prefix
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      surv[i] = valid_r[i] && (cval_r[i] > smp_r);
    end
    full    = surv[WINDOW_MAX-1];
    load[0] = !surv[0];
    for (int i = 1; i < WINDOW_MAX; i++) begin
      load[i] = !surv[i] && surv[i-1];
    end
  end

  assign fill_nxt = (32'(fill_r) < 32'(WINDOW_MAX)) ? fill_r + CNT_W'(1) : fill_r;

  // full deque: front retires and the sample goes to the back cell
  always_comb begin
    if (full) begin
      front_val = cval_r[1];
    end else if (load[0]) begin
      front_val = smp_r;
    end else begin
      front_val = cval_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= WS_W'(1);
      valid_r     <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) ws_r <= cfg_wdata;
      if (cmd.capture && in_first) begin
        valid_r <= '0;
        pos_r   <= '0;
        fill_r  <= '0;
      end
      if (cmd.retire) valid_r <= valid_r >> 1;
      if (cmd.push) begin
        valid_r     <= full ? '1 : (surv | load);
        pos_r       <= pos_r + POS_W'(1);
        fill_r      <= fill_nxt;
        out_valid_r <= (32'(fill_nxt) >= 32'(win_k));
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_r  <= in_sample;
      last_r <= in_last;
    end
    if (cmd.push) begin
      out_max_r  <= front_val;
      out_last_r <= last_r;
    end
    for (int i = 0; i < WINDOW_MAX - 1; i++) begin
      if (cmd.retire || (cmd.push && full)) begin
        cval_r[i] <= cval_r[i+1];
        cpos_r[i] <= cpos_r[i+1];
      end else if (cmd.push && load[i]) begin
        cval_r[i] <= smp_r;
        cpos_r[i] <= pos_r;
      end
    end
    if (cmd.push && (full || load[WINDOW_MAX-1])) begin
      cval_r[WINDOW_MAX-1] <= smp_r;
      cpos_r[WINDOW_MAX-1] <= pos_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_max   = out_max_r;
  assign out_last  = out_last_r;

endmodule

// ===== sv/sliding_window_maximum.sv =====
// Top level of the sliding-window maximum filter: controller plus datapath.
// Depends on swm_pkg, swm_ctrl and swm_dp.
//
//   channel  | ports                         | payload
//   ---------+-------------------------------+--------------------------------
//   input    | in_tvalid/in_tready           | tdata: sample, tuser: first,
//            |                               | tlast: last
//   result   | out_tvalid/out_tready         | tdata: window_max,
//            |                               | tlast: last_window
//   config   | cfg_we/cfg_wdata              | window_size
//
// Each sample is captured, then expired front entries are retired one per cycle
// by the controller's retire loop (at most one while the window size is steady),
// then the push step runs. Reset is synchronous, active low, and empties
// the deque. A result waiting in the output register stalls only the push
// step of the next sample; the next sample is still taken in.
`timescale 1ns / 1ps

module sliding_window_maximum import swm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // [31:0] sample
  input  logic                  in_tuser,   // [0] first
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // [31:0] window_max
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [WS_W-1:0]       cfg_wdata
);

  swm_cmd_t                      cmd;
  swm_status_t                   status;
  logic signed [SAMPLE_BITS-1:0] out_max;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  swm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_first  (in_tuser),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_max   (out_max),
    .out_last  (out_tlast)
  );

  assign out_tdata = TDATA_W'(unsigned'(out_max));

endmodule

// ===== sv/swm_check.sv =====
// Port-level checker for the sliding-window maximum filter, bound to the
// top level. Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_check import swm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a transfer in keeps the input closed through the retire and push steps
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input reopened too early");

  // new results only come out of the push step, never while idle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a sample in work");

endmodule

bind sliding_window_maximum swm_check u_swm_check (.*);

// ===== tb/swm_max_checker.sv =====
// Checker for the sliding-window maximum filter: mirrors the window deque,
// predicts each window maximum and compares it with the result channel.
// Depends on swm_pkg; instantiated beside the filter by tb.
`timescale 1ns / 1ps

module swm_max_checker import swm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [31:0] sample
  input  logic               in_tuser,   // [0] first
  input  logic               in_tlast,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,  // [31:0] window_max
  input  logic               out_tlast,
  input  logic               cfg_we,
  input  logic [WS_W-1:0]    cfg_wdata,
  output int                 mismatches,
  output int                 peaks_owed
);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] peak;
    logic                          last;
  } peak_t;

  logic signed [SAMPLE_BITS-1:0] dq_val [WINDOW_MAX];
  logic [POS_W-1:0]              dq_pos [WINDOW_MAX];
  logic [IDX_W-1:0]              dq_head;
  int                            dq_len;
  int                            fill;
  logic [POS_W-1:0]              next_pos;
  logic [WS_W-1:0]               win_reg;
  peak_t                         peak_q [$];

  task automatic advance_window(input logic signed [SAMPLE_BITS-1:0] s,
                                input logic is_first, input logic is_last);
    int               k;
    logic [IDX_W-1:0] slot;
    logic [POS_W-1:0] age;
    peak_t            e;
    k = (win_reg == '0) ? 1 : (win_reg > WINDOW_MAX) ? WINDOW_MAX : int'(win_reg);
    if (is_first) begin
      dq_head  = '0;
      dq_len   = 0;
      fill     = 0;
      next_pos = '0;
    end
    // drop the front while it is outside the window (ages wrap with position)
    while (dq_len > 0) begin
      age = next_pos - dq_pos[dq_head];
      if (int'(age) < k) break;
      dq_head = dq_head + 1'b1;
      dq_len--;
    end
    // newest entry wins ties
    while (dq_len > 0) begin
      slot = dq_head + IDX_W'(dq_len - 1);
      if (dq_val[slot] > s) break;
      dq_len--;
    end
    if (dq_len >= WINDOW_MAX) begin
      dq_head = dq_head + 1'b1;
      dq_len--;
    end
    slot = dq_head + IDX_W'(dq_len);
    dq_val[slot] = s;
    dq_pos[slot] = next_pos;
    dq_len++;
    next_pos = next_pos + 1'b1;
    if (fill < WINDOW_MAX) fill++;
    if (fill >= k) begin
      e.peak = dq_val[dq_head];
      e.last = is_last;
      peak_q.insert(peak_q.size(), e);
    end
  endtask

  always @(posedge clk) begin : watch
    peak_t e;
    if (!rst_n) begin
      dq_head  = '0;
      dq_len   = 0;
      fill     = 0;
      next_pos = '0;
      win_reg  = WS_W'(1);
      peak_q.delete();
    end else begin
      // results first, so a stray result never meets a fresh expectation
      if (out_tvalid && out_tready) begin
        if (peak_q.size() == 0) begin
          $error("unexpected transfer: window_max %0d last_window %0b",
                 $signed(out_tdata[SAMPLE_BITS-1:0]), out_tlast);
          mismatches++;
        end else begin
          e = peak_q[0];
          peak_q.delete(0);
          if (out_tdata[SAMPLE_BITS-1:0] !== e.peak) begin
            $error("window_max: expected %0d, actual %0d", e.peak,
                   $signed(out_tdata[SAMPLE_BITS-1:0]));
            mismatches++;
          end
          if (out_tlast !== e.last) begin
            $error("last_window: expected %0b, actual %0b", e.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        advance_window($signed(in_tdata[SAMPLE_BITS-1:0]), in_tuser, in_tlast);
      if (cfg_we) win_reg = cfg_wdata;
    end
    peaks_owed <= peak_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the sliding-window maximum filter: reset, window
// settings, sample sequences with random gaps and output stalls, verdict.
// Depends on swm_pkg, sliding_window_maximum and swm_max_checker.
`timescale 1ns / 1ps

module tb import swm_pkg::*;;

  localparam int ITEMS = 1100;

  typedef enum logic [2:0] {
    SEQ_RANDOM,
    SEQ_TIES,
    SEQ_RAMP_UP,
    SEQ_RAMP_DOWN,
    SEQ_EXTREME
  } seq_style_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SPARSE,
    RX_COMB,
    RX_CHOKED
  } rx_mode_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;  // [31:0] sample
  logic               in_tuser   = 1'b0; // [0] first
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;        // [31:0] window_max
  logic               out_tlast;
  logic               cfg_we     = 1'b0;
  logic [WS_W-1:0]    cfg_wdata  = '0;

  int                 mismatches;
  int                 peaks_owed;
  int                 sent       = 0;
  int                 burst_left = 0;
  logic [15:0]        cyc        = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sliding_window_maximum uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  swm_max_checker peak_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .peaks_owed(peaks_owed)
  );

  // receiver: stall pattern chosen by cyc[9:8], cycling through open, sparse, comb and choked
  always @(posedge clk) begin
    cyc <= cyc + 1'b1;
    case (rx_mode_t'(cyc[9:8]))
      RX_OPEN:   out_tready <= 1'b1;
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) != 0);
      RX_COMB:   out_tready <= ((cyc % 7) < 4);
      default:   out_tready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  task automatic put_sample(input logic [SAMPLE_BITS-1:0] s, input logic f,
                            input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= f;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic write_window(input logic [WS_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait out all owed results plus the retire loop of a silent sample
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (peaks_owed != 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input seq_style_t st,
                                                         input int idx);
    case (st)
      SEQ_TIES:      return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
      SEQ_RAMP_UP:   return SAMPLE_BITS'(idx * 3 - 100);
      SEQ_RAMP_DOWN: return SAMPLE_BITS'(100 - idx * 3);
      SEQ_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          2:       return '0;
          3:       return '1;
          default: return SAMPLE_BITS'(1);
        endcase
      end
      default:       return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int               phase;
    int               eff;
    int               len;
    int               runs;
    logic [WS_W-1:0]  win;
    logic             opens;
    seq_style_t       st;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of one after reset: each sample is its own maximum
    put_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}}, 1'b1, 1'b0);
    put_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}}, 1'b0, 1'b0);
    put_sample('0, 1'b0, 1'b1);
    settle();

    // ties, falling values, continuation after last, short sequence
    write_window(WS_W'(3));
    put_sample(SAMPLE_BITS'(10), 1'b1, 1'b0);
    put_sample(SAMPLE_BITS'(10), 1'b0, 1'b0);
    put_sample(SAMPLE_BITS'(4), 1'b0, 1'b0);
    put_sample(SAMPLE_BITS'(-2), 1'b0, 1'b0);
    put_sample(SAMPLE_BITS'(-8), 1'b0, 1'b0);
    put_sample(SAMPLE_BITS'(-8), 1'b0, 1'b1);
    put_sample(SAMPLE_BITS'(100), 1'b0, 1'b0);
    put_sample(SAMPLE_BITS'(1), 1'b1, 1'b0);
    put_sample(SAMPLE_BITS'(2), 1'b0, 1'b1);
    settle();

    // zero window behaves as one
    write_window('0);
    put_sample(SAMPLE_BITS'(-5), 1'b1, 1'b0);
    put_sample(SAMPLE_BITS'(3), 1'b0, 1'b1);
    settle();

    // window resized in the middle of a sequence
    write_window(WS_W'(4));
    put_sample(SAMPLE_BITS'(1), 1'b1, 1'b0);
    put_sample(SAMPLE_BITS'(2), 1'b0, 1'b0);
    put_sample(SAMPLE_BITS'(3), 1'b0, 1'b0);
    put_sample(SAMPLE_BITS'(4), 1'b0, 1'b0);
    settle();
    write_window(WS_W'(2));
    put_sample('0, 1'b0, 1'b0);
    settle();
    write_window(WS_W'(5));
    put_sample(SAMPLE_BITS'(-1), 1'b0, 1'b1);
    settle();

    phase = 0;
    while (sent < ITEMS) begin
      case (phase)
        0:       win = '1;
        1:       win = WS_W'(WINDOW_MAX);
        2:       win = '0;
        3:       win = WS_W'(1);
        4:       win = WS_W'(WINDOW_MAX + 1);
        default: begin
          case ($urandom_range(0, 19))
            0, 1, 2:    win = WS_W'($urandom_range(13, WINDOW_MAX));
            3, 4, 5:    win = WS_W'($urandom_range(0, 127));
            default:    win = WS_W'($urandom_range(1, 12));
          endcase
        end
      endcase
      phase++;
      eff = (win == '0) ? 1 : (win > WINDOW_MAX) ? WINDOW_MAX : int'(win);
      write_window(win);

      runs = $urandom_range(1, 4);
      repeat (runs) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: arbitrary markers
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++)
            put_sample($urandom, ($urandom_range(0, 3) == 0),
                       ($urandom_range(0, 3) == 0));
        end else begin
          st    = seq_style_t'($urandom_range(0, 4));
          opens = ($urandom_range(0, 9) != 0);
          len   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff)
                                              : $urandom_range(eff, 2 * eff + 10);
          for (int i = 0; i < len; i++)
            put_sample(pick_sample(st, i), opens && (i == 0), i == len - 1);
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sliding_window_maximum.f =====
sv/swm_pkg.sv
sv/swm_ctrl.sv
sv/swm_dp.sv
sv/sliding_window_maximum.sv
sv/swm_check.sv
tb/swm_max_checker.sv
tb/tb.sv
